### rtl/dcss_pkg.sv
package dcss_pkg;

  // field widths
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned EN_W     = 4;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // constants
  localparam logic [TICK_W-1:0]  STABLE_MAX     = 8'd255;
  localparam logic [TICK_W-1:0]  DEBOUNCE_RESET = 8'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 14'd9999;
  localparam logic [DIGIT_W-1:0] BCD_MAX        = 4'd9;

  // scan positions, thousands first
  typedef enum logic [POS_W-1:0] {
    POS_THOUSANDS = 2'd0,
    POS_HUNDREDS  = 2'd1,
    POS_TENS      = 2'd2,
    POS_ONES      = 2'd3
  } scan_pos_t;

  // four bcd digits, index 0 is the ones digit
  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // common-cathode segment code, bit0 segment a
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0: code = 7'h3F;
      4'd1: code = 7'h06;
      4'd2: code = 7'h5B;
      4'd3: code = 7'h4F;
      4'd4: code = 7'h66;
      4'd5: code = 7'h6D;
      4'd6: code = 7'h7D;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7F;
      4'd9: code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

  // active-low digit enables per scan position
  function automatic logic [EN_W-1:0] enable_code(input scan_pos_t pos);
    logic [EN_W-1:0] code;
    case (pos)
      POS_THOUSANDS: code = 4'h7;
      POS_HUNDREDS:  code = 4'hE;
      POS_TENS:      code = 4'hD;
      POS_ONES:      code = 4'hB;
      default:       code = 4'hF;
    endcase
    return code;
  endfunction

endpackage

### rtl/dcss_debounce.sv
module dcss_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          level,
  input  logic [dcss_pkg::TICK_W-1:0]   debounce_ticks,
  output logic                          press
);

  logic                          previous_level_r;
  logic                          previous_level_nxt;
  logic                          accepted_level_r;
  logic                          accepted_level_nxt;
  logic [dcss_pkg::TICK_W-1:0]   stable_ticks_r;
  logic [dcss_pkg::TICK_W-1:0]   stable_ticks_nxt;
  logic                          take;

  // stability timer, restart on change, saturate at max
  always_comb begin
    if (level != previous_level_r) begin
      stable_ticks_nxt = '0;
    end else if (stable_ticks_r == dcss_pkg::STABLE_MAX) begin
      stable_ticks_nxt = stable_ticks_r;
    end else begin
      stable_ticks_nxt = stable_ticks_r + 1'b1;
    end
  end

  // accept level once stable long enough, a new low level is a press
  always_comb begin
    take               = (stable_ticks_nxt >= debounce_ticks) && (level != accepted_level_r);
    accepted_level_nxt = take ? level : accepted_level_r;
    previous_level_nxt = level;
    press              = advance && take && !level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_level_r <= 1'b1;
      accepted_level_r <= 1'b0;
      stable_ticks_r   <= '0;
    end else if (advance) begin
      previous_level_r <= previous_level_nxt;
      accepted_level_r <= accepted_level_nxt;
      stable_ticks_r   <= stable_ticks_nxt;
    end
  end

endmodule

### rtl/dcss_counter.sv
module dcss_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          press,
  output logic [dcss_pkg::COUNT_W-1:0]  count_nxt,
  output dcss_pkg::bcd_t                bcd_nxt
);

  logic [dcss_pkg::COUNT_W-1:0]  count_r;
  dcss_pkg::bcd_t                bcd_r;
  logic [dcss_pkg::NUM_DIGITS:0] carry;

  // binary count with wrap at 9999
  always_comb begin
    if (!press) begin
      count_nxt = count_r;
    end else if (count_r == dcss_pkg::COUNT_MAX) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r + 1'b1;
    end
  end

  // bcd shadow of the count, ripple carry over four digits
  always_comb begin
    carry[0] = press;
    for (int i = 0; i < dcss_pkg::NUM_DIGITS; i++) begin
      if (!carry[i]) begin
        bcd_nxt[i]   = bcd_r[i];
        carry[i+1]   = 1'b0;
      end else if (bcd_r[i] == dcss_pkg::BCD_MAX) begin
        bcd_nxt[i]   = '0;
        carry[i+1]   = 1'b1;
      end else begin
        bcd_nxt[i]   = bcd_r[i] + 1'b1;
        carry[i+1]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bcd_r   <= '0;
    end else if (carry[dcss_pkg::NUM_DIGITS] || press) begin
      count_r <= count_nxt;
      bcd_r   <= bcd_nxt;
    end
  end

endmodule

### rtl/debounced_counter_seven_segment_scan.sv
// result: registered, appears in the cycle after its tick request is accepted
// throughput: one tick request per cycle; the output register is refilled in
//   the same cycle it is taken, so a stall only on the output side holds input
// reset: synchronous active-low rst_n clears timer, accepted level, count, scan position
//   and output valid, sets previous level high; debounce_ticks returns to 20
module debounced_counter_seven_segment_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  // input ticks
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dcss_pkg::IN_DATA_W-1:0]    in_tdata,   // [0] button_level, rest zero
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dcss_pkg::OUT_DATA_W-1:0]   out_tdata,  // [6:0] segments, [10:7] digit_enables,
                                                        // [24:11] count_value, rest zero
  // debounce_ticks register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcss_pkg::TICK_W-1:0]       cfg_data
);

  logic [dcss_pkg::TICK_W-1:0]      debounce_ticks_r;
  dcss_pkg::scan_pos_t              scan_pos_r;
  dcss_pkg::scan_pos_t              scan_pos_nxt;
  logic                             out_valid_r;
  logic [dcss_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [dcss_pkg::OUT_DATA_W-1:0]  out_data_nxt;
  logic                             advance;
  logic                             press;
  logic [dcss_pkg::COUNT_W-1:0]     count_nxt;
  dcss_pkg::bcd_t                   bcd_nxt;
  logic [dcss_pkg::DIGIT_W-1:0]     digit;
  logic [dcss_pkg::SEG_W-1:0]       segments;
  logic [dcss_pkg::EN_W-1:0]        digit_enables;

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign advance    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= dcss_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_ticks_r <= cfg_data;
    end
  end

  dcss_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .level          (in_tdata[0]),
    .debounce_ticks (debounce_ticks_r),
    .press          (press)
  );

  dcss_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .press     (press),
    .count_nxt (count_nxt),
    .bcd_nxt   (bcd_nxt)
  );

  // digit select: thousands is bcd digit 3, ones is digit 0
  always_comb begin
    digit         = bcd_nxt[~scan_pos_r];
    segments      = dcss_pkg::seg_code(digit);
    digit_enables = dcss_pkg::enable_code(scan_pos_r);
    scan_pos_nxt  = dcss_pkg::scan_pos_t'(scan_pos_r + 1'b1);
    out_data_nxt  = {7'd0, count_nxt, digit_enables, segments};
  end

  // scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= dcss_pkg::POS_THOUSANDS;
    end else if (advance) begin
      scan_pos_r <= scan_pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### rtl/dcss_checker.sv
module dcss_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dcss_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result follows every accepted tick
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  // exactly one digit enabled
  a_enable_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:7] == 4'h7 || out_tdata[10:7] == 4'hE ||
                    out_tdata[10:7] == 4'hD || out_tdata[10:7] == 4'hB))
    else $error("bad digit enables");

  // count in decimal range, padding zero
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[24:11] <= 14'd9999) && (out_tdata[31:25] == 7'd0))
    else $error("count out of range");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind debounced_counter_seven_segment_scan dcss_checker u_dcss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
